// ===== hw/rtl/xylmi_pkg.sv =====
package xylmi_pkg;

   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_ABS   = 3'd1;
   localparam logic [2:0] OP_REL   = 3'd2;
   localparam logic [2:0] OP_STOP  = 3'd3;
   localparam logic [2:0] OP_QUERY = 3'd4;

   localparam logic       CSR_STEP_SIZE = 1'b0;
   localparam logic       CSR_VELOCITY  = 1'b1;

   localparam int unsigned ALU_W = 86;

   localparam logic [6:0] ELAPSED_MUL_STEPS = 7'd32;
   localparam logic [6:0] SQUARE_STEPS      = 7'd41;
   localparam logic [6:0] SQRT_STEPS        = 7'd42;
   localparam logic [6:0] STEP_MUL_STEPS    = 7'd32;
   localparam logic [6:0] DIV_STEPS         = 7'd74;

   localparam logic [31:0] STEP_SIZE_RESET = 32'd65536;
   localparam logic [31:0] VELOCITY_RESET  = 32'd655360;
   localparam logic [31:0] VELOCITY_MIN    = 32'd6554;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TICK,
      S_CHECK,
      S_ISETUP,
      S_IMUL,
      S_IDIV,
      S_IFIN,
      S_DISPATCH,
      S_MSETUP,
      S_MSQ,
      S_SQRT,
      S_SMSET,
      S_SMUL,
      S_SDIV,
      S_SFIN,
      S_OUT
   } state_type;

   // Q24.16 to whole steps, truncated toward zero
   function automatic logic [23:0] trunc_q16(input logic [39:0] v);
      logic round_up;
      round_up  = v[39] && (v[15:0] != 16'd0);
      trunc_q16 = v[39:16] + {23'd0, round_up};
   endfunction

endpackage

// ===== hw/rtl/xy_linear_move_interpolator.sv =====
// Constant-velocity XY stage model. Each request transaction (tick, absolute move, relative
// move, stop, query) returns exactly one response with the whole-step position and a busy
// flag. The multiplies, divides and square root run bit-serially on one shared 86-bit
// add/subtract unit: computing the current position while moving takes a multiply and a
// divide per axis, and a move adds a square per axis, a square root, a multiply and a
// divide. req_tready is high only while no transaction is in progress.
module xy_linear_move_interpolator
   import xylmi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // target_x[23:0], target_y[47:24]
   input  logic [2:0]  req_tuser,   // operation[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // pos_x[23:0], pos_y[47:24]
   output logic        rsp_tuser,   // busy_res
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   state_type state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   logic [23:0] tx_ff, tx_in, ty_ff, ty_in;
   logic [31:0] step_ff, step_in, vel_ff, vel_in;
   logic [39:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [39:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [39:0] settled_x_ff, settled_x_in, settled_y_ff, settled_y_in;
   logic [39:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [31:0] elapsed_ff, elapsed_in, duration_ff, duration_in;
   logic        moving_ff, moving_in;
   logic [ALU_W-1:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [40:0] mplier_ff, mplier_in;
   logic [47:0] rem_ff, rem_in;
   logic [41:0] root_ff, root_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        axis_ff, axis_in, neg_ff, neg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_px_ff, rsp_px_in, rsp_py_ff, rsp_py_in;
   logic        rsp_busy_ff, rsp_busy_in;

   logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
   logic             alu_sub, alu_ge;
   logic [39:0] s_sel, g_sel;
   logic [40:0] diff, diff_abs, fin_val;
   logic [32:0] elapsed_inc;
   logic [23:0] cur_wx, cur_wy;
   logic [24:0] rel_x, rel_y;
   logic [23:0] gx_whole, gy_whole;
   logic [31:0] vel_eff, dur_q;
   logic        last;

   assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(ALU_W-1){1'b0}}, alu_sub};
   assign alu_ge  = ~alu_sum[ALU_W-1];

   assign s_sel    = axis_ff ? start_y_ff : start_x_ff;
   assign g_sel    = axis_ff ? goal_y_ff : goal_x_ff;
   assign diff     = {g_sel[39], g_sel} - {s_sel[39], s_sel};
   assign diff_abs = diff[40] ? (41'd0 - diff) : diff;
   assign fin_val  = neg_ff ? ({s_sel[39], s_sel} - acc_ff[40:0])
                            : ({s_sel[39], s_sel} + acc_ff[40:0]);
   assign elapsed_inc = {1'b0, elapsed_ff} + 33'd1;
   assign cur_wx   = trunc_q16(cur_x_ff);
   assign cur_wy   = trunc_q16(cur_y_ff);
   assign rel_x    = {cur_wx[23], cur_wx} + {tx_ff[23], tx_ff};
   assign rel_y    = {cur_wy[23], cur_wy} + {ty_ff[23], ty_ff};
   assign vel_eff  = (vel_ff == 32'd0) ? VELOCITY_MIN : vel_ff;
   assign dur_q    = (acc_ff[73:32] != 42'd0) ? 32'hFFFF_FFFF : acc_ff[31:0];
   assign last     = (cnt_ff == 7'd1);

   always_comb begin
      if (rel_x[24] != rel_x[23]) begin
         gx_whole = rel_x[24] ? 24'h800000 : 24'h7FFFFF;
      end else begin
         gx_whole = rel_x[23:0];
      end
      if (rel_y[24] != rel_y[23]) begin
         gy_whole = rel_y[24] ? 24'h800000 : 24'h7FFFFF;
      end else begin
         gy_whole = rel_y[23:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      step_in      = step_ff;
      vel_in       = vel_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      settled_x_in = settled_x_ff;
      settled_y_in = settled_y_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      elapsed_in   = elapsed_ff;
      duration_in  = duration_ff;
      moving_in    = moving_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      axis_in      = axis_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_px_in    = rsp_px_ff;
      rsp_py_in    = rsp_py_ff;
      rsp_busy_in  = rsp_busy_ff;
      alu_a        = acc_ff;
      alu_b        = mcand_ff;
      alu_sub      = 1'b0;
      req_tready   = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_STEP_SIZE: step_in = csr_wdata;
            CSR_VELOCITY:  vel_in  = csr_wdata;
            default:       step_in = step_ff;
         endcase
      end

      // shared unit operand selection
      unique case (state_ff)
         S_IDIV, S_SDIV: begin
            alu_a   = {{(ALU_W-49){1'b0}}, rem_ff, acc_ff[73]};
            alu_b   = mcand_ff;
            alu_sub = 1'b1;
         end
         S_SQRT: begin
            alu_a   = {{(ALU_W-50){1'b0}}, rem_ff, acc_ff[83:82]};
            alu_b   = {{(ALU_W-44){1'b0}}, root_ff, 2'b01};
            alu_sub = 1'b1;
         end
         default: begin
            alu_a   = acc_ff;
            alu_b   = mcand_ff;
            alu_sub = 1'b0;
         end
      endcase

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in    = req_tuser;
               tx_in    = req_tdata[23:0];
               ty_in    = req_tdata[47:24];
               state_in = S_TICK;
            end
         end
         S_TICK: begin
            if (op_ff == OP_TICK && moving_ff) begin
               elapsed_in = elapsed_inc[31:0];
               if (elapsed_inc >= {1'b0, duration_ff}) begin
                  settled_x_in = goal_x_ff;
                  settled_y_in = goal_y_ff;
                  moving_in    = 1'b0;
               end
            end
            state_in = S_CHECK;
         end
         S_CHECK: begin
            axis_in = 1'b0;
            if (moving_ff) begin
               state_in = S_ISETUP;
            end else begin
               cur_x_in = settled_x_ff;
               cur_y_in = settled_y_ff;
               state_in = S_DISPATCH;
            end
         end
         S_ISETUP: begin
            mcand_in  = {{(ALU_W-41){1'b0}}, diff_abs};
            mplier_in = {9'd0, elapsed_ff};
            acc_in    = '0;
            neg_in    = diff[40];
            cnt_in    = ELAPSED_MUL_STEPS;
            state_in  = S_IMUL;
         end
         S_IMUL, S_MSQ, S_SMUL: begin
            if (mplier_ff[0]) begin
               acc_in = alu_sum;
            end
            mcand_in  = {mcand_ff[ALU_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[40:1]};
            cnt_in    = cnt_ff - 7'd1;
            if (last) begin
               unique case (state_ff)
                  S_IMUL: begin
                     mcand_in = {{(ALU_W-32){1'b0}}, duration_ff};
                     rem_in   = '0;
                     cnt_in   = DIV_STEPS;
                     state_in = S_IDIV;
                  end
                  S_MSQ: begin
                     if (!axis_ff) begin
                        axis_in  = 1'b1;
                        state_in = S_MSETUP;
                     end else begin
                        rem_in   = '0;
                        root_in  = '0;
                        cnt_in   = SQRT_STEPS;
                        state_in = S_SQRT;
                     end
                  end
                  default: begin
                     mcand_in = {{(ALU_W-48){1'b0}}, vel_eff, 16'd0};
                     rem_in   = '0;
                     cnt_in   = DIV_STEPS;
                     state_in = S_SDIV;
                  end
               endcase
            end
         end
         S_IDIV, S_SDIV: begin
            rem_in = alu_ge ? alu_sum[47:0] : alu_a[47:0];
            acc_in = {12'd0, acc_ff[72:0], alu_ge};
            cnt_in = cnt_ff - 7'd1;
            if (last) begin
               state_in = (state_ff == S_IDIV) ? S_IFIN : S_SFIN;
            end
         end
         S_IFIN: begin
            if (!axis_ff) begin
               cur_x_in = fin_val[39:0];
               axis_in  = 1'b1;
               state_in = S_ISETUP;
            end else begin
               cur_y_in = fin_val[39:0];
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority case (op_ff)
               OP_ABS, OP_REL: begin
                  start_x_in = cur_x_ff;
                  start_y_in = cur_y_ff;
                  if (op_ff == OP_ABS) begin
                     goal_x_in = {tx_ff, 16'd0};
                     goal_y_in = {ty_ff, 16'd0};
                  end else begin
                     goal_x_in = {gx_whole, 16'd0};
                     goal_y_in = {gy_whole, 16'd0};
                  end
                  elapsed_in = '0;
                  axis_in    = 1'b0;
                  acc_in     = '0;
                  state_in   = S_MSETUP;
               end
               OP_STOP: begin
                  settled_x_in = cur_x_ff;
                  settled_y_in = cur_y_ff;
                  moving_in    = 1'b0;
                  state_in     = S_OUT;
               end
               default: state_in = S_OUT;
            endcase
         end
         S_MSETUP: begin
            mcand_in  = {{(ALU_W-41){1'b0}}, diff_abs};
            mplier_in = diff_abs;
            cnt_in    = SQUARE_STEPS;
            state_in  = S_MSQ;
         end
         S_SQRT: begin
            rem_in  = alu_ge ? alu_sum[47:0] : alu_a[47:0];
            root_in = {root_ff[40:0], alu_ge};
            acc_in  = {acc_ff[83:0], 2'b00};
            cnt_in  = cnt_ff - 7'd1;
            if (last) begin
               state_in = S_SMSET;
            end
         end
         S_SMSET: begin
            acc_in    = '0;
            mcand_in  = {{(ALU_W-42){1'b0}}, root_ff};
            mplier_in = {9'd0, step_ff};
            cnt_in    = STEP_MUL_STEPS;
            state_in  = S_SMUL;
         end
         S_SFIN: begin
            duration_in = (dur_q == 32'd0) ? 32'd1 : dur_q;
            moving_in   = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_px_in    = cur_wx;
               rsp_py_in    = cur_wy;
               rsp_busy_in  = moving_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= STEP_SIZE_RESET;
         vel_ff       <= VELOCITY_RESET;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         settled_x_ff <= '0;
         settled_y_ff <= '0;
         elapsed_ff   <= '0;
         duration_ff  <= 32'd1;
         moving_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         vel_ff       <= vel_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         goal_x_ff    <= goal_x_in;
         goal_y_ff    <= goal_y_in;
         settled_x_ff <= settled_x_in;
         settled_y_ff <= settled_y_in;
         elapsed_ff   <= elapsed_in;
         duration_ff  <= duration_in;
         moving_ff    <= moving_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      cnt_ff      <= cnt_in;
      axis_ff     <= axis_in;
      neg_ff      <= neg_in;
      rsp_px_ff   <= rsp_px_in;
      rsp_py_ff   <= rsp_py_in;
      rsp_busy_ff <= rsp_busy_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_py_ff, rsp_px_ff};
   assign rsp_tuser  = rsp_busy_ff;

endmodule

// ===== verif/tb.sv =====
module tb;
   import xylmi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [2:0]         op;
      logic signed [23:0] tx;
      logic signed [23:0] ty;
   } move_cmd_type;

   typedef struct {
      logic [23:0] px;
      logic [23:0] py;
      logic        busy;
   } stage_pos_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we;
   logic        csr_index;
   logic [31:0] csr_wdata;

   xy_linear_move_interpolator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // stage model state
   logic [31:0] mdl_step;
   logic [31:0] mdl_vel;
   longint      mdl_start_x, mdl_start_y, mdl_goal_x, mdl_goal_y;
   longint      mdl_settled_x, mdl_settled_y;
   logic [31:0] mdl_elapsed, mdl_duration;
   logic        mdl_moving;

   move_cmd_type  cmd_q[$];
   stage_pos_type pos_q[$];
   int         errors = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         hold_req = 0;
   int         hold_left = 0;
   int         stall_cycles = 0;
   logic       req_taken = 1'b0;

   function automatic longint lerp_axis(longint s, longint g);
      longint       diff;
      logic [63:0]  m;
      logic [127:0] prod;
      logic [127:0] off;
      diff = g - s;
      m    = (diff < 0) ? 64'(-diff) : 64'(diff);
      prod = 128'(m) * 128'(mdl_elapsed);
      off  = prod / 128'(mdl_duration);
      return (diff < 0) ? s - longint'(off[63:0]) : s + longint'(off[63:0]);
   endfunction

   function automatic longint now_x();
      return mdl_moving ? lerp_axis(mdl_start_x, mdl_goal_x) : mdl_settled_x;
   endfunction

   function automatic longint now_y();
      return mdl_moving ? lerp_axis(mdl_start_y, mdl_goal_y) : mdl_settled_y;
   endfunction

   function automatic logic [31:0] travel_ms();
      longint       dx, dy;
      logic [127:0] ax, ay, sumsq, root, c, v, d;
      dx    = mdl_goal_x - mdl_start_x;
      dy    = mdl_goal_y - mdl_start_y;
      ax    = (dx < 0) ? 128'(-dx) : 128'(dx);
      ay    = (dy < 0) ? 128'(-dy) : 128'(dy);
      sumsq = ax * ax + ay * ay;
      root  = '0;
      for (int b = 41; b >= 0; b--) begin
         c = root | (128'd1 << b);
         if (c * c <= sumsq)
            root = c;
      end
      v = (mdl_vel == 32'd0) ? 128'(VELOCITY_MIN) : 128'(mdl_vel);
      d = (root * 128'(mdl_step)) / (v << 16);
      if (d > 128'hFFFF_FFFF)
         d = 128'hFFFF_FFFF;
      return (d == 0) ? 32'd1 : d[31:0];
   endfunction

   function automatic longint clamp_steps(longint v);
      if (v > 8388607)
         return 8388607;
      if (v < -8388608)
         return -8388608;
      return v;
   endfunction

   function automatic stage_pos_type apply_cmd(move_cmd_type c);
      stage_pos_type r;
      longint     px, py, gx, gy, sx, sy;
      case (c.op)
         OP_TICK: begin
            if (mdl_moving) begin
               mdl_elapsed++;
               if (mdl_elapsed >= mdl_duration) begin
                  mdl_settled_x = mdl_goal_x;
                  mdl_settled_y = mdl_goal_y;
                  mdl_moving    = 1'b0;
               end
            end
            px = now_x();
            py = now_y();
         end
         OP_ABS, OP_REL: begin
            gx = longint'(c.tx);
            gy = longint'(c.ty);
            if (c.op == OP_REL) begin
               gx = clamp_steps(now_x() / 65536 + gx);
               gy = clamp_steps(now_y() / 65536 + gy);
            end
            sx            = now_x();
            sy            = now_y();
            mdl_start_x   = sx;
            mdl_start_y   = sy;
            mdl_goal_x    = gx * 65536;
            mdl_goal_y    = gy * 65536;
            mdl_elapsed   = '0;
            mdl_duration  = travel_ms();
            mdl_moving    = 1'b1;
            px            = sx;
            py            = sy;
         end
         OP_STOP: begin
            if (mdl_moving) begin
               mdl_settled_x = now_x();
               mdl_settled_y = now_y();
               mdl_moving    = 1'b0;
            end
            px = mdl_settled_x;
            py = mdl_settled_y;
         end
         default: begin
            px = now_x();
            py = now_y();
         end
      endcase
      r.px   = 24'(px / 65536);
      r.py   = 24'(py / 65536);
      r.busy = mdl_moving;
      return r;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         // previous transaction taken at the last edge, or nothing offered
         if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {cmd_q[0].ty, cmd_q[0].tx};
            req_tuser  <= cmd_q[0].op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         pos_q.push_back(apply_cmd(cmd_q[0]));
         void'(cmd_q.pop_front());
      end
   end

   // receiver
   always @(negedge clock) begin
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      stage_pos_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pos_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response pos=(%h,%h) busy=%b", $realtime,
                     rsp_tdata[23:0], rsp_tdata[47:24], rsp_tuser);
         end else begin
            want = pos_q.pop_front();
            if (rsp_tdata[23:0] !== want.px) begin
               errors++;
               $display("%0t: pos_x expected %h actual %h", $realtime, want.px,
                        rsp_tdata[23:0]);
            end
            if (rsp_tdata[47:24] !== want.py) begin
               errors++;
               $display("%0t: pos_y expected %h actual %h", $realtime, want.py,
                        rsp_tdata[47:24]);
            end
            if (rsp_tuser !== want.busy) begin
               errors++;
               $display("%0t: busy expected %b actual %b", $realtime, want.busy,
                        rsp_tuser);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 20000) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_cmd(logic [2:0] op, int x, int y);
      move_cmd_type c;
      c.op = op;
      c.tx = 24'(x);
      c.ty = 24'(y);
      cmd_q.push_back(c);
   endtask

   task automatic write_reg(logic idx, logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_STEP_SIZE)
         mdl_step = val;
      else
         mdl_vel = val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (cmd_q.size() > 0 || pos_q.size() > 0)
         @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic random_cmds(int count, int span);
      int n = 0;
      int k;
      while (n < count) begin
         if ($urandom_range(99) < 75) begin
            if ($urandom_range(1))
               push_cmd(OP_ABS, $urandom_range(2 * span) - span,
                        $urandom_range(2 * span) - span);
            else
               push_cmd(OP_REL, $urandom_range(span) - span / 2,
                        $urandom_range(span) - span / 2);
            n++;
            k = $urandom_range(40, 1);
            for (int i = 0; i < k; i++) begin
               case ($urandom_range(19))
                  0:       push_cmd(OP_STOP, $urandom, $urandom);
                  1:       push_cmd(OP_QUERY, $urandom, $urandom);
                  2:       push_cmd(OP_REL, $urandom_range(10) - 5, $urandom_range(10) - 5);
                  default: push_cmd(OP_TICK, $urandom, $urandom);
               endcase
               n++;
            end
         end else begin
            push_cmd(3'($urandom_range(7)), $urandom, $urandom);
            n++;
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_TICK;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = CSR_STEP_SIZE;
      csr_wdata  = '0;

      mdl_step      = STEP_SIZE_RESET;
      mdl_vel       = VELOCITY_RESET;
      mdl_start_x   = 0;
      mdl_start_y   = 0;
      mdl_goal_x    = 0;
      mdl_goal_y    = 0;
      mdl_settled_x = 0;
      mdl_settled_y = 0;
      mdl_elapsed   = '0;
      mdl_duration  = 32'd1;
      mdl_moving    = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 20;
      recv_idle_pct = 88;
      push_cmd(OP_TICK, 0, 0);
      push_cmd(OP_QUERY, 0, 0);
      push_cmd(OP_STOP, 0, 0);
      push_cmd(OP_ABS, 30, -40);
      push_cmd(OP_TICK, 0, 0);
      push_cmd(OP_QUERY, -1, -1);
      push_cmd(OP_STOP, 0, 0);
      push_cmd(OP_ABS, 0, 0);
      push_cmd(OP_ABS, 0, 0);
      push_cmd(OP_TICK, 0, 0);
      push_cmd(OP_ABS, 8388607, 8388607);
      push_cmd(OP_STOP, 0, 0);
      push_cmd(OP_REL, 8388607, 8388607);
      push_cmd(OP_STOP, 0, 0);
      push_cmd(OP_ABS, -8388608, -8388608);
      push_cmd(OP_STOP, 0, 0);
      push_cmd(OP_REL, -8388608, -8388608);
      push_cmd(OP_STOP, 0, 0);
      push_cmd(OP_ABS, 5, -3);
      push_cmd(OP_TICK, 0, 0);
      push_cmd(3'd5, 0, 0);
      push_cmd(3'd6, -1, 0);
      push_cmd(3'd7, 0, -1);
      drain();
      random_cmds(200, 300);
      drain();

      write_reg(CSR_STEP_SIZE, 32'd1);
      write_reg(CSR_VELOCITY, 32'hFFFF_FFFF);
      random_cmds(200, 8388607);
      drain();

      send_idle_pct = 88;
      recv_idle_pct = 20;
      write_reg(CSR_STEP_SIZE, 32'hFFFF_FFFF);
      write_reg(CSR_VELOCITY, 32'd0);
      random_cmds(150, 50);
      drain();

      write_reg(CSR_STEP_SIZE, 32'd65536);
      write_reg(CSR_VELOCITY, 32'd6554);
      random_cmds(200, 4);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(CSR_STEP_SIZE, 32'h0000_8000);
      write_reg(CSR_VELOCITY, 32'h0004_0000);
      random_cmds(300, 400);
      hold_req = 500;
      drain();

      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
